// File: rtl/rso_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ramped sine oscillator.
package rso_pkg;

	localparam int FREQ_W   = 23;
	localparam int GAIN_W   = 16;
	localparam int LEN_W    = 7;
	localparam int STEP_W   = 30;
	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 15;

	localparam int MAX_BLOCK_DEF  = 64;
	localparam int SINE_DEPTH_DEF = 1024;
	localparam int OUT_DEPTH      = 4;

	localparam logic [STEP_W-1:0] HZ_TO_STEP_RESET = 30'd22906492;

	typedef struct packed {
		logic [FREQ_W-1:0] freq_target;
		logic [GAIN_W-1:0] gain_target;
		logic [LEN_W-1:0]  block_length;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} res_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq_start;
		logic [FREQ_W-1:0] freq_target;
		logic [GAIN_W-1:0] gain_start;
		logic [GAIN_W-1:0] gain_target;
		logic [LEN_W-1:0]  len;
	} job_t;

endpackage

// File: rtl/rso_front.sv
`timescale 1ns / 1ps
// Request intake: drops empty requests, fixes ramp start values and queues jobs.
module rso_front #(
	parameter int MAX_BLOCK = rso_pkg::MAX_BLOCK_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  rso_pkg::req_t req,
	output logic          job_valid,
	input  logic          job_take,
	output rso_pkg::job_t job
);
	import rso_pkg::*;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BLOCK);

	logic              primed_q;
	logic [FREQ_W-1:0] freq_start_q;
	logic [GAIN_W-1:0] gain_start_q;
	job_t              slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              accept;
	logic              enq;
	logic              deq;
	job_t              job_new;

	assign full      = (count_q == 2'd2);
	assign accept    = push && !full;
	assign enq       = accept && (req.block_length != '0);
	assign job_valid = (count_q != 2'd0);
	assign deq       = job_valid && job_take;
	assign job       = slot_q[rd_ptr_q];

	always_comb begin
		job_new.freq_target = req.freq_target;
		job_new.gain_target = req.gain_target;
		job_new.freq_start  = primed_q ? freq_start_q : req.freq_target;
		job_new.gain_start  = primed_q ? gain_start_q : req.gain_target;
		job_new.len         = (req.block_length > LEN_MAX) ? LEN_MAX : req.block_length;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q     <= 1'b0;
			freq_start_q <= '0;
			gain_start_q <= '0;
			wr_ptr_q     <= 1'b0;
			rd_ptr_q     <= 1'b0;
			count_q      <= 2'd0;
		end else begin
			if (enq) begin
				primed_q     <= 1'b1;
				freq_start_q <= req.freq_target;
				gain_start_q <= req.gain_target;
				wr_ptr_q     <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (enq && !deq) begin
				count_q <= count_q + 2'd1;
			end else if (deq && !enq) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_ptr_q] <= job_new;
		end
	end

endmodule

// File: rtl/rso_ramp_div.sv
`timescale 1ns / 1ps
// Serial floor divider of a signed ramp span by the block length, one bit per cycle.
module rso_ramp_div #(
	parameter int DW = 24,
	parameter int NW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dividend,
	input  logic [NW-1:0]        divisor,
	output logic                 busy,
	output logic signed [DW-1:0] quotient,
	output logic [NW-1:0]        remainder
);
	localparam int CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic             neg_q;
	logic [NW-1:0]    div_q;
	logic [DW-1:0]    quo_q;
	logic [NW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW:0]      rem_sh;
	logic             ge;
	logic [NW:0]      rem_nx;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign ge     = (rem_sh >= {1'b0, div_q});
	assign rem_nx = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	assign busy   = busy_q;

	always_comb begin
		if (!neg_q) begin
			quotient  = $signed(quo_q);
			remainder = rem_q;
		end else if (rem_q == '0) begin
			quotient  = $signed(-quo_q);
			remainder = '0;
		end else begin
			quotient  = $signed(~quo_q);
			remainder = div_q - rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DW-1];
			div_q <= divisor;
			quo_q <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= rem_nx[NW-1:0];
		end
	end

endmodule

// File: rtl/rso_synth.sv
`timescale 1ns / 1ps
// Sample engine: ramp sequencer, phase accumulator, quarter-wave sine table and gain.
module rso_synth #(
	parameter int SINE_TABLE_DEPTH = rso_pkg::SINE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [rso_pkg::STEP_W-1:0]   hz_to_step,
	input  logic                         job_valid,
	output logic                         job_take,
	input  rso_pkg::job_t                job,
	output logic                         out_push,
	input  logic                         out_full,
	output rso_pkg::res_t                out_res
);
	import rso_pkg::*;

	localparam int QUARTER = SINE_TABLE_DEPTH / 4;
	localparam int ADDR_W  = $clog2(QUARTER + 1);
	localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int RP_W    = 32 + DEPTH_W;
	localparam int FDW     = FREQ_W + 1;
	localparam int GDW     = GAIN_W + 1;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] HALF_Q30    = 64'd536870912;
	localparam logic [DEPTH_W-1:0] Q1_IDX = DEPTH_W'(QUARTER);
	localparam logic [DEPTH_W-1:0] Q2_IDX = DEPTH_W'(2 * QUARTER);
	localparam logic [DEPTH_W-1:0] Q3_IDX = DEPTH_W'(3 * QUARTER);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_RUN} state_t;

	function automatic logic [MAG_W-1:0] sine_entry(input logic [63:0] x);
		logic [63:0]        t;
		logic signed [63:0] s;
		logic [63:0]        v;
		t = x;
		s = $signed(x);
		t = (t * x) >> 30;
		t = ((t * x) >> 30) / 64'd6;
		s = s - $signed(t);
		t = (t * x) >> 30;
		t = ((t * x) >> 30) / 64'd20;
		s = s + $signed(t);
		t = (t * x) >> 30;
		t = ((t * x) >> 30) / 64'd42;
		s = s - $signed(t);
		t = (t * x) >> 30;
		t = ((t * x) >> 30) / 64'd72;
		s = s + $signed(t);
		t = (t * x) >> 30;
		t = ((t * x) >> 30) / 64'd110;
		s = s - $signed(t);
		t = (t * x) >> 30;
		t = ((t * x) >> 30) / 64'd156;
		s = s + $signed(t);
		if (s < 0) begin
			s = '0;
		end
		v = (($unsigned(s) * 64'd32767) + HALF_Q30) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[MAG_W-1:0];
	endfunction

	logic [MAG_W-1:0] tab_rom [QUARTER+1];

	for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
		localparam logic [63:0] XK = (HALF_PI_Q30 * 64'(k)) / 64'(QUARTER);
		localparam logic [MAG_W-1:0] VK = sine_entry(XK);
		assign tab_rom[k] = VK;
	end

	state_t                   state_q;
	logic [LEN_W-1:0]         len_q;
	logic [LEN_W-1:0]         idx_q;
	logic [FREQ_W-1:0]        fq_q;
	logic [LEN_W-1:0]         fr_q;
	logic [GAIN_W-1:0]        gq_q;
	logic [LEN_W-1:0]         gr_q;
	logic                     adv;
	logic                     div_start;
	logic                     fdiv_busy;
	logic                     gdiv_busy;
	logic signed [FDW-1:0]    fdq;
	logic [LEN_W-1:0]         fdr;
	logic signed [GDW-1:0]    gdq;
	logic [LEN_W-1:0]         gdr;
	logic [LEN_W:0]           fr_sum;
	logic [LEN_W:0]           gr_sum;
	logic                     fc;
	logic                     gc;
	logic [FDW-1:0]           fq_sum;
	logic [GDW-1:0]           gq_sum;
	logic [FREQ_W-1:0]        fq_nx;
	logic [GAIN_W-1:0]        gq_nx;
	logic [LEN_W-1:0]         fr_nx;
	logic [LEN_W-1:0]         gr_nx;
	logic                     is_last;

	logic                     vld_s1;
	logic [FREQ_W-1:0]        f_s1;
	logic [GAIN_W-1:0]        g_s1;
	logic                     last_s1;
	logic                     vld_s2;
	logic [FREQ_W+STEP_W-1:0] prod_s2;
	logic [GAIN_W-1:0]        g_s2;
	logic                     last_s2;
	logic [31:0]              phase_acc_q;
	logic [31:0]              phase_nx;
	logic                     vld_s3;
	logic [31:0]              phase_s3;
	logic [GAIN_W-1:0]        g_s3;
	logic                     last_s3;
	logic [RP_W-1:0]          rprod;
	logic [DEPTH_W-1:0]       tidx;
	logic [1:0]               quad_nx;
	logic [DEPTH_W-1:0]       r_nx;
	logic                     vld_s4;
	logic [ADDR_W-1:0]        r_s4;
	logic [1:0]               quad_s4;
	logic [GAIN_W-1:0]        g_s4;
	logic                     last_s4;
	logic [ADDR_W-1:0]        addr;
	logic                     vld_s5;
	logic [MAG_W-1:0]         tab_s5;
	logic                     neg_s5;
	logic [GAIN_W-1:0]        g_s5;
	logic                     last_s5;
	logic                     vld_s6;
	logic [MAG_W+GAIN_W-1:0]  mprod_s6;
	logic                     neg_s6;
	logic                     last_s6;
	logic [31:0]              rnd;
	logic [16:0]              mag;

	assign adv       = !(vld_s6 && out_full);
	assign div_start = (state_q == ST_IDLE) && job_valid;
	assign job_take  = div_start;

	rso_ramp_div #(.DW(FDW), .NW(LEN_W)) u_fdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  ($signed({1'b0, job.freq_target} - {1'b0, job.freq_start})),
		.divisor   (job.len),
		.busy      (fdiv_busy),
		.quotient  (fdq),
		.remainder (fdr)
	);

	rso_ramp_div #(.DW(GDW), .NW(LEN_W)) u_gdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  ($signed({1'b0, job.gain_target} - {1'b0, job.gain_start})),
		.divisor   (job.len),
		.busy      (gdiv_busy),
		.quotient  (gdq),
		.remainder (gdr)
	);

	always_comb begin
		fr_sum  = {1'b0, fr_q} + {1'b0, fdr};
		gr_sum  = {1'b0, gr_q} + {1'b0, gdr};
		fc      = (fr_sum >= {1'b0, len_q});
		gc      = (gr_sum >= {1'b0, len_q});
		fr_nx   = fc ? LEN_W'(fr_sum - {1'b0, len_q}) : fr_sum[LEN_W-1:0];
		gr_nx   = gc ? LEN_W'(gr_sum - {1'b0, len_q}) : gr_sum[LEN_W-1:0];
		fq_sum  = {1'b0, fq_q} + $unsigned(fdq) + FDW'(fc);
		gq_sum  = {1'b0, gq_q} + $unsigned(gdq) + GDW'(gc);
		fq_nx   = fq_sum[FREQ_W-1:0];
		gq_nx   = gq_sum[GAIN_W-1:0];
		is_last = (idx_q == LEN_W'(len_q - LEN_W'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			idx_q   <= '0;
			fq_q    <= '0;
			fr_q    <= '0;
			gq_q    <= '0;
			gr_q    <= '0;
			vld_s1  <= 1'b0;
			f_s1    <= '0;
			g_s1    <= '0;
			last_s1 <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1 <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						len_q   <= job.len;
						fq_q    <= job.freq_start;
						gq_q    <= job.gain_start;
						fr_q    <= '0;
						gr_q    <= '0;
						idx_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!fdiv_busy && !gdiv_busy) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (adv) begin
						vld_s1  <= 1'b1;
						f_s1    <= fq_nx;
						g_s1    <= gq_nx;
						last_s1 <= is_last;
						fq_q    <= fq_nx;
						fr_q    <= fr_nx;
						gq_q    <= gq_nx;
						gr_q    <= gr_nx;
						idx_q   <= idx_q + LEN_W'(1);
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign phase_nx = phase_acc_q + prod_s2[47:16];
	assign rprod    = {{DEPTH_W{1'b0}}, phase_s3} * RP_W'(SINE_TABLE_DEPTH);
	assign addr     = quad_s4[0] ? (ADDR_W'(QUARTER) - r_s4) : r_s4;

	always_comb begin
		tidx = rprod[RP_W-1:32];
		if (tidx >= Q3_IDX) begin
			quad_nx = 2'd3;
			r_nx    = tidx - Q3_IDX;
		end else if (tidx >= Q2_IDX) begin
			quad_nx = 2'd2;
			r_nx    = tidx - Q2_IDX;
		end else if (tidx >= Q1_IDX) begin
			quad_nx = 2'd1;
			r_nx    = tidx - Q1_IDX;
		end else begin
			quad_nx = 2'd0;
			r_nx    = tidx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			phase_acc_q <= '0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			if (vld_s2) begin
				phase_acc_q <= phase_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2  <= {{STEP_W{1'b0}}, f_s1} * {{FREQ_W{1'b0}}, hz_to_step};
			g_s2     <= g_s1;
			last_s2  <= last_s1;
			phase_s3 <= phase_nx;
			g_s3     <= g_s2;
			last_s3  <= last_s2;
			r_s4     <= ADDR_W'(r_nx);
			quad_s4  <= quad_nx;
			g_s4     <= g_s3;
			last_s4  <= last_s3;
			tab_s5   <= tab_rom[addr];
			neg_s5   <= quad_s4[1];
			g_s5     <= g_s4;
			last_s5  <= last_s4;
			mprod_s6 <= {{GAIN_W{1'b0}}, tab_s5} * {{MAG_W{1'b0}}, g_s5};
			neg_s6   <= neg_s5;
			last_s6  <= last_s5;
		end
	end

	assign rnd      = {1'b0, mprod_s6} + 32'd16384;
	assign mag      = rnd[31:15];
	assign out_push = vld_s6 && !out_full;

	always_comb begin
		out_res.last = last_s6;
		if (neg_s6) begin
			out_res.sample = (mag > 17'd32768) ? 16'sh8000 : $signed(SAMPLE_W'(17'd0 - mag));
		end else begin
			out_res.sample = (mag > 17'd32767) ? 16'sh7fff : $signed(mag[SAMPLE_W-1:0]);
		end
	end

endmodule

// File: rtl/rso_out_queue.sv
`timescale 1ns / 1ps
// Result queue that holds finished samples until the consumer pops them.
module rso_out_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  rso_pkg::res_t din,
	output logic          empty,
	input  logic          pop,
	output rso_pkg::res_t dout
);
	import rso_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	res_t             mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr;
	logic             rd;

	assign full  = (count_q == CNT_W'(OUT_DEPTH));
	assign empty = (count_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// File: rtl/ramped_sine_oscillator.sv
`timescale 1ns / 1ps
// Top level of the ramped sine oscillator: a block request yields N samples, one per cycle
// while the result queue has room. A block of N samples keeps the sample engine busy for
// a setup part and then its N samples; the 24-step serial ramp divider sets the setup part,
// the sample pipeline then emits one per cycle unless the result queue is full.
// Asynchronous active-low reset clears all control state and restores hz_to_step to its
// default; the first block after reset starts at its own targets, without a ramp.
module ramped_sine_oscillator #(
	parameter int MAX_BLOCK        = rso_pkg::MAX_BLOCK_DEF,
	parameter int SINE_TABLE_DEPTH = rso_pkg::SINE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [rso_pkg::STEP_W-1:0] cfg_wdata,
	input  logic                       push,
	output logic                       full,
	input  rso_pkg::req_t              req,
	output logic                       empty,
	input  logic                       pop,
	output rso_pkg::res_t              res
);
	import rso_pkg::*;

	logic [STEP_W-1:0] hz_to_step_q;
	logic              job_valid;
	logic              job_take;
	job_t              job;
	logic              out_push;
	logic              out_full;
	res_t              out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hz_to_step_q <= HZ_TO_STEP_RESET;
		end else if (cfg_wen) begin
			hz_to_step_q <= cfg_wdata;
		end
	end

	rso_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job       (job)
	);

	rso_synth #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_synth (
		.clk        (clk),
		.arst_n     (arst_n),
		.hz_to_step (hz_to_step_q),
		.job_valid  (job_valid),
		.job_take   (job_take),
		.job        (job),
		.out_push   (out_push),
		.out_full   (out_full),
		.out_res    (out_res)
	);

	rso_out_queue u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.full   (out_full),
		.din    (out_res),
		.empty  (empty),
		.pop    (pop),
		.dout   (res)
	);

endmodule
